FILE: rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int GLYPH_W    = 8;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [GLYPH_W-1:0] CH_BELL      = 8'd7;
  localparam logic [GLYPH_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [GLYPH_W-1:0] CH_TAB       = 8'd9;
  localparam logic [GLYPH_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [GLYPH_W-1:0] CH_VTAB      = 8'd11;
  localparam logic [GLYPH_W-1:0] CH_FORMFEED  = 8'd12;
  localparam logic [GLYPH_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [GLYPH_W-1:0] CH_SPACE     = 8'd32;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_GLYPH,
    CMD_BS,
    CMD_NL,
    CMD_CR,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [GLYPH_W-1:0]   glyph;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
  } cmd_t;

  // first field in the highest bits
  typedef struct packed {
    logic [GLYPH_W-1:0] read_glyph;
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic               scrolled;
    logic [GLYPH_W-1:0] written_glyph;
    logic [COL_W-1:0]   written_col;
    logic [ROW_W-1:0]   written_row;
    logic               cell_written;
  } result_t;

  localparam int OUT_PAD_W = OUT_TDATA_W - $bits(result_t);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } back_state_e;

endpackage

FILE: rtl/tcw_front.sv
`timescale 1ns / 1ps

module tcw_front
  import tcw_pkg::*;
(
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  init_busy_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [GLYPH_W-1:0] char_code;

  assign char_code     = s_axis_tdata[GLYPH_W-1:0];
  assign s_axis_tready = !q_full_i && !init_busy_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd_o.glyph = char_code;
    cmd_o.row   = s_axis_tdata[GLYPH_W +: ROW_W];
    cmd_o.col   = s_axis_tdata[GLYPH_W+ROW_W +: COL_W];
    if (s_axis_tuser) begin
      cmd_o.kind = CMD_READ;
    end else begin
      unique case (char_code)
        CH_BACKSPACE: cmd_o.kind = CMD_BS;
        CH_NEWLINE:   cmd_o.kind = CMD_NL;
        CH_RETURN:    cmd_o.kind = CMD_CR;
        CH_BELL, CH_TAB, CH_VTAB, CH_FORMFEED: cmd_o.kind = CMD_NOP;
        default:      cmd_o.kind = CMD_GLYPH;
      endcase
    end
  end

endmodule

FILE: rtl/tcw_queue.sv
`timescale 1ns / 1ps

module tcw_queue
  import tcw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  // two-entry queue between front and back
  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/tcw_back.sv
`timescale 1ns / 1ps

module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  cmd_t    q_cmd_i,
  output logic    q_pop_o,
  output logic    init_busy_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_result_o
);

  localparam int Cells = ROWS * COLUMNS;
  localparam int AddrW = $clog2(Cells);
  localparam logic [AddrW-1:0] ColsA    = AddrW'(COLUMNS);
  localparam logic [AddrW-1:0] CellLast = AddrW'(Cells - 1);
  localparam logic [ROW_W-1:0] RowLast  = ROW_W'(ROWS - 1);
  localparam logic [ROW_W:0]   RowsW    = (ROW_W+1)'(ROWS);
  localparam logic [COL_W-1:0] ColLast  = COL_W'(COLUMNS - 1);

  logic [GLYPH_W-1:0] glyph_mem_q [Cells];
  logic [GLYPH_W-1:0] rdata_q;

  back_state_e      state_q, state_d;
  logic [ROW_W-1:0] top_q, top_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] clr_last_q, clr_last_d;
  logic             out_valid_q;
  result_t          out_q;

  logic               out_free, out_load;
  result_t            res;
  logic               we, rd_en;
  logic [AddrW-1:0]   waddr, rd_addr;
  logic [GLYPH_W-1:0] wdata;
  logic               rd_in_range;

  // character decode on the queue head
  logic               ch_wr, ch_adv, ch_scroll;
  logic [COL_W-1:0]   ch_wcol, ch_ncol;
  logic [GLYPH_W-1:0] ch_glyph;
  logic [AddrW-1:0]   ch_addr, top_base;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] row);
    logic [ROW_W:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= RowsW) sum = sum - RowsW;
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                 input logic [COL_W-1:0] col);
    return AddrW'(AddrW'(prow) * ColsA) + AddrW'(col);
  endfunction

  assign init_busy_o = state_q == ST_INIT;
  assign m_valid_o   = out_valid_q;
  assign m_result_o  = out_q;
  assign out_free    = !out_valid_q || m_ready_i;
  assign rd_in_range = (q_cmd_i.row <= RowLast) && (q_cmd_i.col <= ColLast);
  assign rd_addr     = cell_addr(phys_row(top_q, q_cmd_i.row), q_cmd_i.col);
  assign top_base    = cell_addr(top_q, '0);

  always_comb begin
    ch_wr    = 1'b0;
    ch_adv   = 1'b0;
    ch_wcol  = col_q;
    ch_ncol  = col_q;
    ch_glyph = q_cmd_i.glyph;
    unique case (q_cmd_i.kind)
      CMD_BS: begin
        ch_wr    = 1'b1;
        ch_glyph = CH_SPACE;
        ch_wcol  = (col_q != '0) ? col_q - 1'b1 : col_q;
        ch_ncol  = ch_wcol;
      end
      CMD_NL: begin
        ch_ncol = '0;
        ch_adv  = 1'b1;
      end
      CMD_CR: ch_ncol = '0;
      CMD_GLYPH: begin
        ch_wr = 1'b1;
        if (col_q == ColLast) begin
          ch_ncol = '0;
          ch_adv  = 1'b1;
        end else begin
          ch_ncol = col_q + 1'b1;
        end
      end
      CMD_READ, CMD_NOP: ;
      default: ;
    endcase
    ch_scroll = ch_adv && (row_q == RowLast);
    ch_addr   = cell_addr(phys_row(top_q, row_q), ch_wcol);
  end

  always_comb begin
    state_d    = state_q;
    top_d      = top_q;
    row_d      = row_q;
    col_d      = col_q;
    clr_d      = clr_q;
    clr_last_d = clr_last_q;
    we         = 1'b0;
    waddr      = clr_q;
    wdata      = '0;
    rd_en      = 1'b0;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    res            = '0;
    res.cursor_row = row_q;
    res.cursor_col = col_q;
    unique case (state_q)
      ST_INIT, ST_SCROLL: begin
        we = 1'b1;
        if (clr_q == clr_last_q) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.kind == CMD_READ) begin
            if (rd_in_range) begin
              rd_en   = 1'b1;
              state_d = ST_READ;
            end else begin
              out_load = 1'b1;
            end
          end else begin
            we    = ch_wr;
            waddr = ch_addr;
            wdata = ch_glyph;
            col_d = ch_ncol;
            if (ch_adv && !ch_scroll) row_d = row_q + 1'b1;
            if (ch_scroll) begin
              // old top row becomes the new bottom line
              top_d      = (top_q == RowLast) ? '0 : top_q + 1'b1;
              clr_d      = top_base;
              clr_last_d = top_base + ColsA - 1'b1;
              state_d    = ST_SCROLL;
            end
            out_load = 1'b1;
            res.cell_written  = ch_wr;
            res.written_row   = ch_wr ? row_q : '0;
            res.written_col   = ch_wr ? ch_wcol : '0;
            res.written_glyph = ch_wr ? ch_glyph : '0;
            res.scrolled      = ch_scroll;
            res.cursor_row    = row_d;
            res.cursor_col    = ch_ncol;
          end
        end
      end
      ST_READ: begin
        out_load       = 1'b1;
        res.read_glyph = rdata_q;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      top_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      clr_q       <= '0;
      clr_last_q  <= CellLast;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      top_q      <= top_d;
      row_q      <= row_d;
      col_q      <= col_d;
      clr_q      <= clr_d;
      clr_last_q <= clr_last_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      glyph_mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= glyph_mem_q[rd_addr];
    end
  end

  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= RowLast) && (col_q <= ColLast))
    else $error("cursor left the screen");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_ready_i))
    else $error("pending result overwritten");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE))
    else $error("queue popped while busy");

  a_read_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (state_q == ST_READ) && out_load)
    else $error("cell read not completed");

endmodule

FILE: rtl/text_console_char_writer_top.sv
// A character beat passes the command queue and the result register; a read also
// passes rdata_q. One character per cycle while m_axis_tready is high and no
// scroll runs; a read holds the back end until its result loads, a scroll while
// it clears the new bottom line (one write port). Reset: cursor and top line go to
// zero, then ROWS*COLUMNS cells (2000 by default) are zeroed with s_axis_tready low.
`timescale 1ns / 1ps

module text_console_char_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // char_code[7:0], read_row[12:8], read_col[19:13], zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // cell_written, written_row, written_col, written_glyph, scrolled,
  // cursor_row, cursor_col, read_glyph, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic    push, q_full, q_valid, q_pop, init_busy;
  cmd_t    cmd_in, cmd_head;
  result_t result;

  tcw_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .init_busy_i   (init_busy),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  tcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (cmd_head)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (cmd_head),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_result_o  (result)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, result};

endmodule
